FILE: rtl/sbpp_pkg.sv
// ----------------------------------------------------------------------------
// sbpp_pkg
// Shared types, codes and the level weight fraction table of the
// softmin-biased partition picker.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  localparam int KEY_W     = 10;
  localparam int LEVEL_W   = 8;
  localparam int RAND_W    = 16;
  localparam int KIND_W    = 2;
  localparam int LVL_MAX_W = 12;
  localparam int NODE_W    = 20;
  localparam int DECAY_W   = 24;
  localparam int FRAC_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [NODE_W-1:0]    NODE_MAX    = 20'hFFFFF;
  localparam logic [DECAY_W-1:0]   DECAY_RESET = 24'd94548;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SELECT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_SELECT,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   part_id;
    logic [LEVEL_W-1:0] cost_level;
    logic [RAND_W-1:0]  random_fraction;
    logic [RAND_W-1:0]  random_pick;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] chosen_partition;
    logic             found;
    logic             bad_removal;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic                 key_ok;
    logic [KEY_W-1:0]     key;
    logic [LVL_MAX_W-1:0] lvl;
    logic [RAND_W-1:0]    rf;
    logic [RAND_W-1:0]    rp;
  } cmd_t;

  typedef struct packed {
    logic [DECAY_W-1:0] decay;
    logic               flat_weight;
  } cfg_t;

  typedef logic [FRAC_W-1:0] frac_tab_t [256];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t       tab;
    longint unsigned t;
    t = 64'd1 << 30;
    for (int k = 0; k < 256; k++) begin
      if (k > 0) begin
        t = (t * 64'd1070838486 + (64'd1 << 29)) >> 30;
      end
      tab[k] = FRAC_W'(t >> 14);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

FILE: rtl/softmin_biased_partition_picker.sv
// ----------------------------------------------------------------------------
// softmin_biased_partition_picker
// Partition set with softmin-weighted random selection of a partition.
// ----------------------------------------------------------------------------
// Commands enter a two-deep queue and are run one at a time by the back end.
// Insert and remove run a partition table read and, when a level's
// population changes, a level table update and the weight pipeline. A
// select walks the levels in ascending order through the single level table
// read port, up to LEVELS levels, then scans the partition table one slot
// per cycle, up to PARTITIONS slots. A write to the decay or ignore register
// rebuilds the weight sum before the next command. After reset a clearing
// pass over both tables runs while full is held high.
module softmin_biased_partition_picker #(
  parameter int PARTITIONS = 1024,
  parameter int LEVELS     = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  sbpp_pkg::in_item_t                 in_data_i,
  output logic                               empty,
  input  logic                               pop,
  output sbpp_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [sbpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbpp_pkg::DECAY_W-1:0]       cfg_wdata_i
);

  sbpp_pkg::cfg_t cfg_q;
  sbpp_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready, clearing, recalc;

  assign recalc = cfg_we_i &&
                  (cfg_idx_i == sbpp_pkg::REG_DECAY || cfg_idx_i == sbpp_pkg::REG_IGNORE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay       <= sbpp_pkg::DECAY_RESET;
      cfg_q.flat_weight <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbpp_pkg::REG_DECAY:  cfg_q.decay       <= cfg_wdata_i;
        sbpp_pkg::REG_IGNORE: cfg_q.flat_weight <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sbpp_front #(.PARTITIONS(PARTITIONS), .LEVELS(LEVELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .clearing_i  (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sbpp_back #(.PARTITIONS(PARTITIONS), .LEVELS(LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .recalc_i    (recalc),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .clearing_o  (clearing),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/sbpp_ram.sv
// ----------------------------------------------------------------------------
// sbpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sbpp_front.sv
// ----------------------------------------------------------------------------
// sbpp_front
// Input queue: decodes each transaction into a command and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
module sbpp_front #(
  parameter int PARTITIONS = 1024,
  parameter int LEVELS     = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sbpp_pkg::in_item_t in_data_i,
  input  logic               clearing_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output sbpp_pkg::cmd_t     cmd_o
);

  sbpp_pkg::cmd_t mem_q [2];
  sbpp_pkg::cmd_t dec;
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push_ok, pop_ok;

  always_comb begin
    dec.key_ok = 32'(in_data_i.part_id) < PARTITIONS;
    dec.key    = in_data_i.part_id;
    dec.rf     = in_data_i.random_fraction;
    dec.rp     = in_data_i.random_pick;
    if (32'(in_data_i.cost_level) >= LEVELS) begin
      dec.lvl = sbpp_pkg::LVL_MAX_W'(LEVELS - 1);
    end else begin
      dec.lvl = sbpp_pkg::LVL_MAX_W'(in_data_i.cost_level);
    end
    unique case (in_data_i.kind)
      sbpp_pkg::KIND_INSERT: dec.op = sbpp_pkg::OP_INSERT;
      sbpp_pkg::KIND_REMOVE: dec.op = sbpp_pkg::OP_REMOVE;
      sbpp_pkg::KIND_SELECT: dec.op = sbpp_pkg::OP_SELECT;
      default:               dec.op = sbpp_pkg::OP_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2) || clearing_i;
  assign push_ok     = push && !full;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop_ok      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_q <= !wr_q;
      end
      if (pop_ok) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= dec;
    end
  end

endmodule

FILE: rtl/sbpp_back.sv
// ----------------------------------------------------------------------------
// sbpp_back
// Command engine: partition and level tables, weight sum upkeep, softmin
// level walk, member scan and the result register.
// ----------------------------------------------------------------------------
module sbpp_back #(
  parameter int PARTITIONS = 1024,
  parameter int LEVELS     = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbpp_pkg::cfg_t      cfg_i,
  input  logic                recalc_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  sbpp_pkg::cmd_t      cmd_i,
  output logic                clearing_o,
  output logic                empty,
  input  logic                pop,
  output sbpp_pkg::out_item_t out_data_o
);

  localparam int AW    = $clog2(PARTITIONS);
  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = $clog2(PARTITIONS + 1);
  localparam int PCW   = $clog2(PARTITIONS + 1);
  localparam int SW    = PW + sbpp_pkg::FRAC_W;
  localparam int TW    = SW + sbpp_pkg::RAND_W;
  localparam int EW    = LW + sbpp_pkg::DECAY_W;
  localparam int IW    = PW + sbpp_pkg::RAND_W;
  localparam int NW    = sbpp_pkg::NODE_W;
  localparam int DW    = 1 + LW + NW;
  localparam int CLR_N = (PARTITIONS > LEVELS) ? PARTITIONS : LEVELS;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_P_EVAL  = 5'd2;
  localparam logic [4:0] S_POP     = 5'd3;
  localparam logic [4:0] S_W1      = 5'd4;
  localparam logic [4:0] S_W2      = 5'd5;
  localparam logic [4:0] S_W3      = 5'd6;
  localparam logic [4:0] S_RC_RD   = 5'd7;
  localparam logic [4:0] S_RC_POP  = 5'd8;
  localparam logic [4:0] S_RC_ACC  = 5'd9;
  localparam logic [4:0] S_SEL_RD  = 5'd10;
  localparam logic [4:0] S_SEL_POP = 5'd11;
  localparam logic [4:0] S_SEL_ACC = 5'd12;
  localparam logic [4:0] S_SEL_END = 5'd13;
  localparam logic [4:0] S_IDX     = 5'd14;
  localparam logic [4:0] S_SCAN    = 5'd15;

  localparam logic [1:0] CTX_UPD = 2'd0;
  localparam logic [1:0] CTX_RC  = 2'd1;
  localparam logic [1:0] CTX_SEL = 2'd2;

  logic [4:0]    state_q, state_d;
  logic [1:0]    ctx_q, ctx_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] ccnt_q, ccnt_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          res_valid_q, res_valid_d;
  logic          have_q, have_d;
  logic          sv_q, sv_d;

  sbpp_pkg::op_e             op_q, op_d;
  sbpp_pkg::out_item_t       res_q, res_d;
  logic [AW-1:0]             key_q, key_d;
  logic [LW-1:0]             lvl_q, lvl_d;
  logic [LW-1:0]             lcnt_q, lcnt_d;
  logic [LW-1:0]             first_q, first_d;
  logic [LW-1:0]             chosen_q, chosen_d;
  logic [PW-1:0]             pop_q, pop_d;
  logic [PW-1:0]             fpop_q, fpop_d;
  logic [PW-1:0]             npop_q, npop_d;
  logic [PW-1:0]             idx_q, idx_d;
  logic [PW-1:0]             seen_q, seen_d;
  logic [PCW-1:0]            pcnt_q, pcnt_d;
  logic [AW-1:0]             paddr_q, paddr_d;
  logic                      flag_q, flag_d;
  logic [EW-1:0]             e_q, e_d;
  logic [sbpp_pkg::FRAC_W-1:0] w_q, w_d;
  logic [SW-1:0]             share_q, share_d;
  logic [SW-1:0]             cum_q, cum_d;
  logic [TW-1:0]             target_q, target_d;
  logic [sbpp_pkg::RAND_W-1:0] rp_q, rp_d;

  logic          part_we;
  logic [AW-1:0] part_waddr, part_raddr;
  logic [DW-1:0] part_wdata, part_rdata;
  logic          pop_we;
  logic [LW-1:0] pop_waddr, pop_raddr;
  logic [PW-1:0] pop_wdata, pop_rdata;

  logic          p_pres;
  logic [LW-1:0] p_lvl;
  logic [NW-1:0] p_nodes, n_dec;
  logic [PW-1:0] np;
  logic [SW-1:0] cum_n;
  logic [IW-1:0] iprod;
  logic          issue;

  sbpp_ram #(.WIDTH(DW), .DEPTH(PARTITIONS)) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (part_we),
    .waddr_i (part_waddr),
    .wdata_i (part_wdata),
    .raddr_i (part_raddr),
    .rdata_o (part_rdata)
  );

  sbpp_ram #(.WIDTH(PW), .DEPTH(LEVELS)) u_pop_ram (
    .clk_i   (clk_i),
    .we_i    (pop_we),
    .waddr_i (pop_waddr),
    .wdata_i (pop_wdata),
    .raddr_i (pop_raddr),
    .rdata_o (pop_rdata)
  );

  assign p_pres     = part_rdata[DW-1];
  assign p_lvl      = part_rdata[DW-2:NW];
  assign p_nodes    = part_rdata[NW-1:0];
  assign n_dec      = (p_nodes != '0) ? p_nodes - NW'(1) : '0;
  assign cum_n      = cum_q + share_q;
  assign iprod      = IW'(rp_q) * IW'(npop_q);
  assign issue      = 32'(pcnt_q) < PARTITIONS;
  assign clearing_o = state_q == S_CLEAR;
  assign empty      = !res_valid_q;
  assign out_data_o = res_q;

  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    pend_d      = pend_q || recalc_i;
    ccnt_d      = ccnt_q;
    sum_d       = sum_q;
    res_valid_d = res_valid_q && !pop;
    res_d       = res_q;
    have_d      = have_q;
    sv_d        = sv_q;
    op_d        = op_q;
    key_d       = key_q;
    lvl_d       = lvl_q;
    lcnt_d      = lcnt_q;
    first_d     = first_q;
    chosen_d    = chosen_q;
    pop_d       = pop_q;
    fpop_d      = fpop_q;
    npop_d      = npop_q;
    idx_d       = idx_q;
    seen_d      = seen_q;
    pcnt_d      = pcnt_q;
    paddr_d     = paddr_q;
    flag_d      = flag_q;
    e_d         = e_q;
    w_d         = w_q;
    share_d     = share_q;
    cum_d       = cum_q;
    target_d    = target_q;
    rp_d        = rp_q;
    cmd_ready_o = 1'b0;
    part_we     = 1'b0;
    part_waddr  = key_q;
    part_wdata  = '0;
    part_raddr  = key_q;
    pop_we      = 1'b0;
    pop_waddr   = lvl_q;
    pop_wdata   = '0;
    pop_raddr   = lvl_q;
    np          = '0;

    unique case (state_q)
      S_CLEAR: begin
        part_we    = 32'(ccnt_q) < PARTITIONS;
        part_waddr = ccnt_q[AW-1:0];
        pop_we     = 32'(ccnt_q) < LEVELS;
        pop_waddr  = ccnt_q[LW-1:0];
        ccnt_d     = ccnt_q + CW'(1);
        if (32'(ccnt_q) == CLR_N - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        part_raddr = AW'(cmd_i.key);
        if (pend_q) begin
          pend_d  = recalc_i;
          lcnt_d  = '0;
          sum_d   = '0;
          ctx_d   = CTX_RC;
          state_d = S_RC_RD;
        end else if (cmd_valid_i && !res_valid_q) begin
          cmd_ready_o = 1'b1;
          op_d        = cmd_i.op;
          key_d       = AW'(cmd_i.key);
          lvl_d       = cmd_i.lvl[LW-1:0];
          rp_d        = cmd_i.rp;
          unique case (cmd_i.op) inside
            sbpp_pkg::OP_INSERT, sbpp_pkg::OP_REMOVE: begin
              if (cmd_i.key_ok) begin
                state_d = S_P_EVAL;
              end else begin
                res_valid_d = 1'b1;
                res_d = '{chosen_partition: '0, found: 1'b0,
                          bad_removal: cmd_i.op == sbpp_pkg::OP_REMOVE};
              end
            end
            sbpp_pkg::OP_SELECT: begin
              target_d = TW'(cmd_i.rf) * TW'(sum_q);
              lcnt_d   = '0;
              cum_d    = '0;
              have_d   = 1'b0;
              ctx_d    = CTX_SEL;
              state_d  = S_SEL_RD;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
            end
          endcase
        end
      end
      S_P_EVAL: begin
        if (op_q == sbpp_pkg::OP_INSERT) begin
          part_we = 1'b1;
          if (p_pres) begin
            part_wdata = {1'b1, p_lvl,
                          (p_nodes < sbpp_pkg::NODE_MAX) ? p_nodes + NW'(1) : p_nodes};
            res_valid_d = 1'b1;
            res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
            state_d = S_IDLE;
          end else begin
            part_wdata = {1'b1, lvl_q, NW'(1)};
            pop_raddr  = lvl_q;
            state_d    = S_POP;
          end
        end else if (!p_pres) begin
          res_valid_d = 1'b1;
          res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b1};
          state_d = S_IDLE;
        end else begin
          part_we = 1'b1;
          if (n_dec != '0) begin
            part_wdata  = {1'b1, p_lvl, n_dec};
            res_valid_d = 1'b1;
            res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
            state_d = S_IDLE;
          end else begin
            part_wdata = '0;
            lvl_d      = p_lvl;
            pop_raddr  = p_lvl;
            state_d    = S_POP;
          end
        end
      end
      S_POP: begin
        pop_we = 1'b1;
        if (op_q == sbpp_pkg::OP_INSERT) begin
          pop_wdata = pop_rdata + PW'(1);
          flag_d    = !cfg_i.flat_weight || pop_rdata == '0;
        end else begin
          np        = (pop_rdata != '0) ? pop_rdata - PW'(1) : '0;
          pop_wdata = np;
          flag_d    = !cfg_i.flat_weight || np == '0;
        end
        ctx_d   = CTX_UPD;
        state_d = S_W1;
      end
      S_W1: begin
        e_d     = EW'(lvl_q) * EW'(cfg_i.decay);
        state_d = S_W2;
      end
      S_W2: begin
        if (e_q[EW-1:16] >= (EW-16)'(17)) begin
          w_d = '0;
        end else begin
          w_d = sbpp_pkg::FRAC_TAB[e_q[15:8]] >> e_q[20:16];
        end
        state_d = S_W3;
      end
      S_W3: begin
        share_d = cfg_i.flat_weight ? SW'(w_q) : SW'(w_q) * SW'(pop_q);
        unique case (ctx_q)
          CTX_RC:  state_d = S_RC_ACC;
          CTX_SEL: state_d = S_SEL_ACC;
          default: begin
            if (flag_q) begin
              if (op_q == sbpp_pkg::OP_INSERT) begin
                sum_d = sum_q + SW'(w_q);
              end else begin
                sum_d = (sum_q >= SW'(w_q)) ? sum_q - SW'(w_q) : '0;
              end
            end
            res_valid_d = 1'b1;
            res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
            state_d = S_IDLE;
          end
        endcase
      end
      S_RC_RD: begin
        pop_raddr = lcnt_q;
        state_d   = S_RC_POP;
      end
      S_RC_POP: begin
        pop_d   = pop_rdata;
        lvl_d   = lcnt_q;
        state_d = S_W1;
      end
      S_RC_ACC: begin
        if (pop_q != '0) begin
          sum_d = sum_q + share_q;
        end
        if (pend_q || lcnt_q == LW'(LEVELS - 1)) begin
          state_d = S_IDLE;
        end else begin
          lcnt_d  = lcnt_q + LW'(1);
          state_d = S_RC_RD;
        end
      end
      S_SEL_RD: begin
        pop_raddr = lcnt_q;
        state_d   = S_SEL_POP;
      end
      S_SEL_POP: begin
        pop_d = pop_rdata;
        if (pop_rdata == '0) begin
          if (lcnt_q == LW'(LEVELS - 1)) begin
            state_d = S_SEL_END;
          end else begin
            lcnt_d  = lcnt_q + LW'(1);
            state_d = S_SEL_RD;
          end
        end else begin
          if (!have_q) begin
            first_d = lcnt_q;
            fpop_d  = pop_rdata;
            have_d  = 1'b1;
          end
          lvl_d   = lcnt_q;
          state_d = S_W1;
        end
      end
      S_SEL_ACC: begin
        cum_d = cum_n;
        if (target_q <= {cum_n, 16'b0}) begin
          chosen_d = lvl_q;
          npop_d   = pop_q;
          state_d  = S_IDX;
        end else if (lcnt_q == LW'(LEVELS - 1)) begin
          state_d = S_SEL_END;
        end else begin
          lcnt_d  = lcnt_q + LW'(1);
          state_d = S_SEL_RD;
        end
      end
      S_SEL_END: begin
        if (!have_q) begin
          res_valid_d = 1'b1;
          res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
          state_d = S_IDLE;
        end else begin
          chosen_d = first_q;
          npop_d   = fpop_q;
          state_d  = S_IDX;
        end
      end
      S_IDX: begin
        idx_d   = iprod[IW-1:16];
        pcnt_d  = '0;
        seen_d  = '0;
        sv_d    = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        part_raddr = pcnt_q[AW-1:0];
        sv_d       = issue;
        if (issue) begin
          pcnt_d  = pcnt_q + PCW'(1);
          paddr_d = pcnt_q[AW-1:0];
        end
        if (sv_q && p_pres && p_lvl == chosen_q) begin
          if (seen_q == idx_q) begin
            res_valid_d = 1'b1;
            res_d   = '{chosen_partition: sbpp_pkg::KEY_W'(paddr_q), found: 1'b1,
                        bad_removal: 1'b0};
            state_d = S_IDLE;
          end else begin
            seen_d = seen_q + PW'(1);
          end
        end else if (!sv_q && !issue) begin
          res_valid_d = 1'b1;
          res_d   = '{chosen_partition: '0, found: 1'b0, bad_removal: 1'b0};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ctx_q       <= CTX_UPD;
      pend_q      <= 1'b0;
      ccnt_q      <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
      have_q      <= 1'b0;
      sv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      pend_q      <= pend_d;
      ccnt_q      <= ccnt_d;
      sum_q       <= sum_d;
      res_valid_q <= res_valid_d;
      have_q      <= have_d;
      sv_q        <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    res_q    <= res_d;
    key_q    <= key_d;
    lvl_q    <= lvl_d;
    lcnt_q   <= lcnt_d;
    first_q  <= first_d;
    chosen_q <= chosen_d;
    pop_q    <= pop_d;
    fpop_q   <= fpop_d;
    npop_q   <= npop_d;
    idx_q    <= idx_d;
    seen_q   <= seen_d;
    pcnt_q   <= pcnt_d;
    paddr_q  <= paddr_d;
    flag_q   <= flag_d;
    e_q      <= e_d;
    w_q      <= w_d;
    share_q  <= share_d;
    cum_q    <= cum_d;
    target_q <= target_d;
    rp_q     <= rp_d;
  end

endmodule
